/* rtl/core/m3h_pkg.sv */
// Package with constants, types and helpers of the MurmurHash3 x64-128 core.
package m3h_pkg;

  localparam logic [63:0] C1 = 64'h87C37B91114253D5;
  localparam logic [63:0] C2 = 64'h4CF5AD432745937F;
  localparam logic [63:0] F1 = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] F2 = 64'hC4CEB9FE1A85EC53;
  localparam logic [63:0] M1 = 64'h0000000052DCE729;
  localparam logic [63:0] M2 = 64'h0000000038495AB5;
  localparam logic [63:0] BLOCK_BYTES = 64'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K1A,
    ST_K1B,
    ST_K2A,
    ST_K2B,
    ST_MIX1,
    ST_MIX2,
    ST_FOLD,
    ST_F1A,
    ST_F1B,
    ST_F2A,
    ST_F2B,
    ST_DONE
  } m3h_state_t;

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_ROT31,
    PRE_ROT33,
    PRE_XSH33
  } m3h_pre_t;

  typedef enum logic [2:0] {
    MRG_NONE,
    MRG_SEED,
    MRG_MIX1,
    MRG_MIX2,
    MRG_FOLD
  } m3h_mrg_op_t;

  typedef struct packed {
    logic        load;
    logic        mul_a;
    logic        mul_b;
    m3h_pre_t    pre;
    logic [63:0] cst;
    logic [63:0] data;
  } m3h_lane_cmd_t;

  typedef struct packed {
    m3h_mrg_op_t op;
    logic        use_tail;
    logic [3:0]  tail_cnt;
  } m3h_mrg_cmd_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

/* rtl/core/m3h_if.sv */
// Request channel interfaces for message blocks and hash results.
interface m3h_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;
  logic [4:0]  valid_bytes;
  logic        last_block;

  modport source (output valid, output block_low, output block_high,
                  output valid_bytes, output last_block, input ready);
  modport sink   (input valid, input block_low, input block_high,
                  input valid_bytes, input last_block, output ready);
endinterface

interface m3h_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_low;
  logic [63:0] hash_high;

  modport source (output valid, output hash_low, output hash_high, input ready);
  modport sink   (input valid, input hash_low, input hash_high, output ready);
endinterface

/* rtl/core/m3h_lane.sv */
// Hash lane: pre-transform plus 64-bit constant multiply on one word, split into a mul_a and a mul_b step.
module m3h_lane (
  input  logic                   clk,
  input  m3h_pkg::m3h_lane_cmd_t cmd,
  output logic [63:0]            value
);

  logic [63:0] v_r;
  logic [63:0] p_ll_r;
  logic [31:0] p_cr_r;
  logic [63:0] x;
  logic [63:0] p_ll_nxt;
  logic [31:0] p_cr_nxt;

  always_comb begin
    case (cmd.pre)
      m3h_pkg::PRE_NONE:  x = v_r;
      m3h_pkg::PRE_ROT31: x = {v_r[32:0], v_r[63:33]};
      m3h_pkg::PRE_ROT33: x = {v_r[30:0], v_r[63:31]};
      m3h_pkg::PRE_XSH33: x = v_r ^ (v_r >> 33);
      default:            x = v_r;
    endcase
    p_ll_nxt = 64'(x[31:0]) * 64'(cmd.cst[31:0]);
    p_cr_nxt = (x[31:0] * cmd.cst[63:32]) + (x[63:32] * cmd.cst[31:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      p_ll_r <= p_ll_nxt;
      p_cr_r <= p_cr_nxt;
    end
    if (cmd.load) begin
      v_r <= cmd.data;
    end else if (cmd.mul_b) begin
      v_r <= p_ll_r + {p_cr_r, 32'd0};
    end
  end

  assign value = v_r;

endmodule

/* rtl/core/m3h_merge.sv */
// Merge stage: holds the hash state, mixes lane words in and forms the result.
module m3h_merge (
  input  logic                  clk,
  input  m3h_pkg::m3h_mrg_cmd_t cmd,
  input  logic [31:0]           seed,
  input  logic [63:0]           k1,
  input  logic [63:0]           k2,
  output logic [63:0]           fold1,
  output logic [63:0]           fold2,
  output logic [63:0]           res1,
  output logic [63:0]           res2
);

  logic [63:0] h1_r;
  logic [63:0] h2_r;
  logic [63:0] total_r;
  logic [63:0] h1_nxt;
  logic [63:0] h2_nxt;
  logic [63:0] total_nxt;
  logic [63:0] t1;
  logic [63:0] t2;
  logic [63:0] len;
  logic [63:0] f1;
  logic [63:0] f2;

  always_comb begin
    h1_nxt    = h1_r;
    h2_nxt    = h2_r;
    total_nxt = total_r;
    t1 = h1_r ^ k1;
    t1 = {t1[36:0], t1[63:37]} + h2_r;
    t2 = h2_r ^ k2;
    t2 = {t2[32:0], t2[63:33]} + h1_r;
    len = total_r + 64'(cmd.tail_cnt);
    fold1 = h1_r ^ len ^ (cmd.use_tail ? k1 : 64'd0);
    fold2 = h2_r ^ len ^ (cmd.use_tail ? k2 : 64'd0);
    fold1 = fold1 + fold2;
    fold2 = fold2 + fold1;
    case (cmd.op)
      m3h_pkg::MRG_SEED: begin
        h1_nxt    = 64'(seed);
        h2_nxt    = 64'(seed);
        total_nxt = '0;
      end
      m3h_pkg::MRG_MIX1: begin
        h1_nxt = (t1 << 2) + t1 + m3h_pkg::M1;
      end
      m3h_pkg::MRG_MIX2: begin
        h2_nxt    = (t2 << 2) + t2 + m3h_pkg::M2;
        total_nxt = total_r + m3h_pkg::BLOCK_BYTES;
      end
      default: begin
      end
    endcase
    f1   = k1 ^ (k1 >> 33);
    f2   = k2 ^ (k2 >> 33);
    res1 = f1 + f2;
    res2 = f2 + res1;
  end

  always_ff @(posedge clk) begin
    h1_r    <= h1_nxt;
    h2_r    <= h2_nxt;
    total_r <= total_nxt;
  end

endmodule

/* rtl/core/murmur3_x64_128_hash.sv */
// Top level of the MurmurHash3 x64-128 core: sequencer, lanes, merge, output register.
// A non-last block runs K1A, K1B, K2A, K2B, MIX1 and MIX2 from accept to next ready.
// A last block runs K1A to K2B, then FOLD, F1A, F1B, F2A, F2B and DONE (MIX1, MIX2 if full);
// the hash is valid the cycle after DONE loads it into the output register.
// Each A/B state pair drives one split 64-bit constant multiply in each lane.
// Reset (rst_n low, synchronous) idles the sequencer, clears the seed to zero
// and closes any open message.
module murmur3_x64_128_hash (
  input  logic              clk,
  input  logic              rst_n,
  m3h_in_if.sink            in_ch,
  m3h_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);

  m3h_pkg::m3h_state_t    state_r;
  m3h_pkg::m3h_state_t    state_nxt;
  m3h_pkg::m3h_lane_cmd_t lane1_cmd;
  m3h_pkg::m3h_lane_cmd_t lane2_cmd;
  m3h_pkg::m3h_mrg_cmd_t  mrg_cmd;

  logic [31:0] seed_r;
  logic        open_r;
  logic        full_r;
  logic        last_r;
  logic [3:0]  tail_r;
  logic        out_valid_r;
  logic [63:0] out_low_r;
  logic [63:0] out_high_r;

  logic        accept;
  logic        in_full;
  logic        out_load;
  logic [63:0] k1;
  logic [63:0] k2;
  logic [63:0] fold1;
  logic [63:0] fold2;
  logic [63:0] res1;
  logic [63:0] res2;

  assign accept  = in_ch.valid && in_ch.ready;
  assign in_full = !in_ch.last_block || (in_ch.valid_bytes >= 5'd16);

  always_comb begin
    state_nxt        = state_r;
    in_ch.ready      = 1'b0;
    out_load         = 1'b0;
    lane1_cmd        = '0;
    lane2_cmd        = '0;
    lane1_cmd.pre    = m3h_pkg::PRE_NONE;
    lane2_cmd.pre    = m3h_pkg::PRE_NONE;
    mrg_cmd.op       = m3h_pkg::MRG_NONE;
    mrg_cmd.use_tail = !full_r;
    mrg_cmd.tail_cnt = tail_r;
    case (state_r)
      m3h_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          lane1_cmd.load = 1'b1;
          lane2_cmd.load = 1'b1;
          if (in_full) begin
            lane1_cmd.data = in_ch.block_low;
            lane2_cmd.data = in_ch.block_high;
          end else begin
            lane1_cmd.data = in_ch.block_low & m3h_pkg::byte_mask(in_ch.valid_bytes[3:0]);
            lane2_cmd.data = in_ch.valid_bytes[3]
                ? (in_ch.block_high & m3h_pkg::byte_mask({1'b0, in_ch.valid_bytes[2:0]}))
                : 64'd0;
          end
          if (!open_r) begin
            mrg_cmd.op = m3h_pkg::MRG_SEED;
          end
          state_nxt = m3h_pkg::ST_K1A;
        end
      end
      m3h_pkg::ST_K1A: begin
        lane1_cmd.mul_a = 1'b1;
        lane2_cmd.mul_a = 1'b1;
        lane1_cmd.cst   = m3h_pkg::C1;
        lane2_cmd.cst   = m3h_pkg::C2;
        state_nxt       = m3h_pkg::ST_K1B;
      end
      m3h_pkg::ST_K1B: begin
        lane1_cmd.mul_b = 1'b1;
        lane2_cmd.mul_b = 1'b1;
        state_nxt       = m3h_pkg::ST_K2A;
      end
      m3h_pkg::ST_K2A: begin
        lane1_cmd.mul_a = 1'b1;
        lane2_cmd.mul_a = 1'b1;
        lane1_cmd.pre   = m3h_pkg::PRE_ROT31;
        lane2_cmd.pre   = m3h_pkg::PRE_ROT33;
        lane1_cmd.cst   = m3h_pkg::C2;
        lane2_cmd.cst   = m3h_pkg::C1;
        state_nxt       = m3h_pkg::ST_K2B;
      end
      m3h_pkg::ST_K2B: begin
        lane1_cmd.mul_b = 1'b1;
        lane2_cmd.mul_b = 1'b1;
        state_nxt       = full_r ? m3h_pkg::ST_MIX1 : m3h_pkg::ST_FOLD;
      end
      m3h_pkg::ST_MIX1: begin
        mrg_cmd.op = m3h_pkg::MRG_MIX1;
        state_nxt  = m3h_pkg::ST_MIX2;
      end
      m3h_pkg::ST_MIX2: begin
        mrg_cmd.op = m3h_pkg::MRG_MIX2;
        state_nxt  = last_r ? m3h_pkg::ST_FOLD : m3h_pkg::ST_IDLE;
      end
      m3h_pkg::ST_FOLD: begin
        mrg_cmd.op     = m3h_pkg::MRG_FOLD;
        lane1_cmd.load = 1'b1;
        lane2_cmd.load = 1'b1;
        lane1_cmd.data = fold1;
        lane2_cmd.data = fold2;
        state_nxt      = m3h_pkg::ST_F1A;
      end
      m3h_pkg::ST_F1A: begin
        lane1_cmd.mul_a = 1'b1;
        lane2_cmd.mul_a = 1'b1;
        lane1_cmd.pre   = m3h_pkg::PRE_XSH33;
        lane2_cmd.pre   = m3h_pkg::PRE_XSH33;
        lane1_cmd.cst   = m3h_pkg::F1;
        lane2_cmd.cst   = m3h_pkg::F1;
        state_nxt       = m3h_pkg::ST_F1B;
      end
      m3h_pkg::ST_F1B: begin
        lane1_cmd.mul_b = 1'b1;
        lane2_cmd.mul_b = 1'b1;
        state_nxt       = m3h_pkg::ST_F2A;
      end
      m3h_pkg::ST_F2A: begin
        lane1_cmd.mul_a = 1'b1;
        lane2_cmd.mul_a = 1'b1;
        lane1_cmd.pre   = m3h_pkg::PRE_XSH33;
        lane2_cmd.pre   = m3h_pkg::PRE_XSH33;
        lane1_cmd.cst   = m3h_pkg::F2;
        lane2_cmd.cst   = m3h_pkg::F2;
        state_nxt       = m3h_pkg::ST_F2B;
      end
      m3h_pkg::ST_F2B: begin
        lane1_cmd.mul_b = 1'b1;
        lane2_cmd.mul_b = 1'b1;
        state_nxt       = m3h_pkg::ST_DONE;
      end
      m3h_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = m3h_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = m3h_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= m3h_pkg::ST_IDLE;
      seed_r      <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (accept) begin
        open_r <= !in_ch.last_block;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      full_r <= in_full;
      last_r <= in_ch.last_block;
      tail_r <= in_full ? 4'd0 : in_ch.valid_bytes[3:0];
    end
    if (out_load) begin
      out_low_r  <= res1;
      out_high_r <= res2;
    end
  end

  m3h_lane u_lane1 (
    .clk   (clk),
    .cmd   (lane1_cmd),
    .value (k1)
  );

  m3h_lane u_lane2 (
    .clk   (clk),
    .cmd   (lane2_cmd),
    .value (k2)
  );

  m3h_merge u_merge (
    .clk   (clk),
    .cmd   (mrg_cmd),
    .seed  (seed_r),
    .k1    (k1),
    .k2    (k2),
    .fold1 (fold1),
    .fold2 (fold2),
    .res1  (res1),
    .res2  (res2)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hash_low  = out_low_r;
  assign out_ch.hash_high = out_high_r;

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == m3h_pkg::ST_DONE && (!out_valid_r || out_ch.ready)) |=> out_valid_r)
    else $error("finished hash not loaded into output register");

  a_open_after_body: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_ch.last_block) |=> (open_r && full_r))
    else $error("non-last block did not keep message open as full block");

  a_tail_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == m3h_pkg::ST_K2B && !full_r) |=> (state_r == m3h_pkg::ST_FOLD))
    else $error("tail block skipped fold step");

  a_body_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == m3h_pkg::ST_MIX2 && !last_r) |=> (state_r == m3h_pkg::ST_IDLE && !out_load))
    else $error("non-last block did not return to idle");

endmodule
